// ----- rtl/core/dtf_pkg.sv -----
// Shared constants, types and tables for the decimal text to fixed point unit.
`timescale 1ns / 1ps

package dtf_pkg;

    localparam int MAX_FRAC_DIGITS = 9;
    localparam int FRAC_BITS       = 28;
    localparam int QUEUE_DEPTH     = 2;

    localparam int LIMIT_W = 30;
    localparam int VALUE_W = 31;
    localparam int QUOT_W  = FRAC_BITS + 2;
    localparam int CMP_W   = (QUOT_W > LIMIT_W) ? QUOT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 30'h2000_0000;
    localparam logic [VALUE_W-1:0] VALUE_POS_MAX = 31'h2000_0000;
    localparam logic [VALUE_W-1:0] VALUE_NEG_MIN = 31'h6000_0000;

    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_IDX_LIMIT = 1'b0;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_POINT = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef enum logic [5:0] {
        PH_LEAD   = 6'b000001,
        PH_SIGNED = 6'b000010,
        PH_INT    = 6'b000100,
        PH_POINT  = 6'b001000,
        PH_FRAC   = 6'b010000,
        PH_TRAIL  = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_HOLD = 3'b100
    } back_state_t;

    typedef struct packed {
        logic       negative;
        logic       failed;
        logic [1:0] whole;
    } dtf_flags_t;

    function automatic logic [31:0] pow10(input logic [3:0] n);
        logic [31:0] p;
        case (n)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            default: p = 32'd1000000000;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/core/decimal_text_to_fixed_point_unit.sv -----
// Top level: APB limit register, parser, job queue and converter.
// Throughput: one character per cycle while the job queue has room. The converter takes
//   a new job only after registering the previous result. Each job passes the queue, the
//   one-bit-per-cycle restoring divider (not on a parse error) and the output register.
// Input stalls only when QUEUE_DEPTH finished strings wait for the converter.
// Reset (rst_n low, asynchronous): parser back to leading whitespace, queue and output
//   empty, magnitude_limit = 2.0; no clearing pass, ready as soon as reset is released.
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_unit
    import dtf_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = MAX_FRAC_DIGITS,
    parameter int QUEUE_SLOTS         = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] char_code
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [30:0] value, [31] zero pad
    output logic              m_axis_tuser,   // [0] error
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int DIG_W = $clog2(10 ** MAX_FRACTION_DIGITS);
    localparam int CNT_W = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int JOB_W = $bits(dtf_flags_t) + DIG_W + CNT_W;

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               reg_hit;

    logic               f_job_valid;
    dtf_flags_t         f_flags;
    logic [DIG_W-1:0]   f_digits;
    logic [CNT_W-1:0]   f_count;
    logic               q_full;
    logic               q_not_empty;
    logic               b_ready;
    logic [JOB_W-1:0]   q_out;
    dtf_flags_t         b_flags;
    logic [DIG_W-1:0]   b_digits;
    logic [CNT_W-1:0]   b_count;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_IDX_LIMIT);
    assign prdata  = reg_hit ? 32'(limit_reg) : 32'd0;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && pready && reg_hit)
            limit_next = pwdata[LIMIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else
            limit_reg <= limit_next;
    end

    dtf_front #(
        .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .job_valid    (f_job_valid),
        .job_ready    (!q_full),
        .job_flags    (f_flags),
        .job_digits   (f_digits),
        .job_count    (f_count)
    );

    dtf_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_SLOTS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_job_valid),
        .push_data({f_flags, f_digits, f_count}),
        .full     (q_full),
        .pop      (q_not_empty && b_ready),
        .pop_data (q_out),
        .not_empty(q_not_empty)
    );

    assign {b_flags, b_digits, b_count} = q_out;

    dtf_back #(
        .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .limit        (limit_reg),
        .job_valid    (q_not_empty),
        .job_ready    (b_ready),
        .job_flags    (b_flags),
        .job_digits   (b_digits),
        .job_count    (b_count),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

// ----- rtl/core/dtf_front.sv -----
// Character parser: classifies each byte and emits one job per terminator.
`timescale 1ns / 1ps

module dtf_front
    import dtf_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = MAX_FRAC_DIGITS,
    localparam int DIG_W = $clog2(10 ** MAX_FRACTION_DIGITS),
    localparam int CNT_W = $clog2(MAX_FRACTION_DIGITS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] char_code
    output logic             job_valid,
    input  logic             job_ready,
    output dtf_flags_t       job_flags,
    output logic [DIG_W-1:0] job_digits,
    output logic [CNT_W-1:0] job_count
);

    phase_t           phase_reg, phase_next;
    logic             negative_reg, negative_next;
    logic [1:0]       whole_reg, whole_next;
    logic [DIG_W-1:0] digits_reg, digits_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             failed_reg, failed_next;

    logic             accept;
    logic             is_digit;
    logic             is_space;
    logic [7:0]       dsub;
    logic [3:0]       d;
    logic [1:0]       whole_add;
    logic             frac_room;
    logic [DIG_W+3:0] digits_ext;
    logic [DIG_W+3:0] digits_sum;

    assign s_axis_tready = job_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign job_valid     = accept && (s_axis_tdata == CH_NUL);

    assign is_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    assign is_space = (s_axis_tdata == CH_SPACE) ||
                      ((s_axis_tdata >= CH_TAB) && (s_axis_tdata <= CH_CR));
    assign dsub     = s_axis_tdata - CH_ZERO;
    assign d        = dsub[3:0];

    assign whole_add  = (whole_reg != 2'd0) ? 2'd3 : ((d > 4'd3) ? 2'd3 : d[1:0]);
    assign frac_room  = count_reg < CNT_W'(MAX_FRACTION_DIGITS);
    assign digits_ext = (DIG_W + 4)'(digits_reg);
    assign digits_sum = (digits_ext << 3) + (digits_ext << 1) + (DIG_W + 4)'(d);

    assign job_flags.negative = negative_reg;
    assign job_flags.failed   = failed_reg ||
                                !((phase_reg == PH_INT) || (phase_reg == PH_FRAC) ||
                                  (phase_reg == PH_TRAIL));
    assign job_flags.whole    = whole_reg;
    assign job_digits         = digits_reg;
    assign job_count          = count_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        whole_next    = whole_reg;
        digits_next   = digits_reg;
        count_next    = count_reg;
        failed_next   = failed_reg;
        if (accept)
        begin
            if (s_axis_tdata == CH_NUL)
            begin
                phase_next    = PH_LEAD;
                negative_next = 1'b0;
                whole_next    = 2'd0;
                digits_next   = '0;
                count_next    = '0;
                failed_next   = 1'b0;
            end
            else if (!failed_reg)
            begin
                case (phase_reg)
                    PH_LEAD:
                    begin
                        if (is_space)
                        begin
                        end
                        else if ((s_axis_tdata == CH_PLUS) || (s_axis_tdata == CH_MINUS))
                        begin
                            negative_next = (s_axis_tdata == CH_MINUS);
                            phase_next    = PH_SIGNED;
                        end
                        else if (is_digit)
                        begin
                            whole_next = whole_add;
                            phase_next = PH_INT;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_SIGNED:
                    begin
                        if (is_digit)
                        begin
                            whole_next = whole_add;
                            phase_next = PH_INT;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_INT:
                    begin
                        if (is_digit)
                            whole_next = whole_add;
                        else if (s_axis_tdata == CH_POINT)
                            phase_next = PH_POINT;
                        else if (is_space)
                            phase_next = PH_TRAIL;
                        else
                            failed_next = 1'b1;
                    end
                    PH_POINT, PH_FRAC:
                    begin
                        if (is_digit)
                        begin
                            phase_next = PH_FRAC;
                            if (frac_room)
                            begin
                                digits_next = digits_sum[DIG_W-1:0];
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        else if (is_space && (phase_reg == PH_FRAC))
                        begin
                            phase_next = PH_TRAIL;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_TRAIL:
                    begin
                        if (!is_space)
                            failed_next = 1'b1;
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            negative_reg <= 1'b0;
            whole_reg    <= 2'd0;
            digits_reg   <= '0;
            count_reg    <= '0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            whole_reg    <= whole_next;
            digits_reg   <= digits_next;
            count_reg    <= count_next;
            failed_reg   <= failed_next;
        end
    end

endmodule

// ----- rtl/core/dtf_queue.sv -----
// Small FIFO carrying parsed jobs from the parser to the converter.
`timescale 1ns / 1ps

module dtf_queue
    import dtf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int FILL_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    logic [WIDTH-1:0]  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- rtl/core/dtf_back.sv -----
// Converter: bit-serial fraction division, range check, sign and output register.
`timescale 1ns / 1ps

module dtf_back
    import dtf_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = MAX_FRAC_DIGITS,
    localparam int DIG_W = $clog2(10 ** MAX_FRACTION_DIGITS),
    localparam int CNT_W = $clog2(MAX_FRACTION_DIGITS + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LIMIT_W-1:0] limit,
    input  logic               job_valid,
    output logic               job_ready,
    input  dtf_flags_t         job_flags,
    input  logic [DIG_W-1:0]   job_digits,
    input  logic [CNT_W-1:0]   job_count,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,   // [30:0] value, [31] zero pad
    output logic               m_axis_tuser    // [0] error
);

    localparam int REM_W  = DIG_W + 1;
    localparam int STEP_W = $clog2(FRAC_BITS);

    back_state_t          state_reg, state_next;
    logic                 neg_reg, neg_next;
    logic                 err_reg, err_next;
    logic [1:0]           whole_reg, whole_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIG_W-1:0]     scale_reg, scale_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic                 out_error_reg, out_error_next;

    logic                 pop;
    logic [31:0]          scale_full;
    logic [REM_W-1:0]     rem_dbl;
    logic [REM_W-1:0]     scale_ext;
    logic                 ge;
    logic [QUOT_W-1:0]    quot;
    logic                 over;
    logic                 bad;
    logic [VALUE_W-1:0]   mag;
    logic                 out_free;

    assign job_ready = (state_reg == BK_IDLE);
    assign pop       = job_valid && job_ready;

    assign scale_full = pow10(4'(job_count));
    assign rem_dbl    = {rem_reg[REM_W-2:0], 1'b0};
    assign scale_ext  = REM_W'(scale_reg);
    assign ge         = rem_dbl >= scale_ext;

    assign quot = {whole_reg, frac_reg};
    assign over = (CMP_W'(quot) > CMP_W'(limit)) ||
                  ((CMP_W'(quot) == CMP_W'(limit)) && (rem_reg != '0));
    assign bad  = err_reg || over;
    assign mag  = VALUE_W'(quot);

    assign out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_value_reg};
    assign m_axis_tuser  = out_error_reg;

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        err_next       = err_reg;
        whole_next     = whole_reg;
        frac_next      = frac_reg;
        rem_next       = rem_reg;
        scale_next     = scale_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_error_next = out_error_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    neg_next   = job_flags.negative;
                    err_next   = job_flags.failed;
                    whole_next = job_flags.whole;
                    frac_next  = '0;
                    rem_next   = REM_W'(job_digits);
                    scale_next = scale_full[DIG_W-1:0];
                    step_next  = '0;
                    state_next = job_flags.failed ? BK_HOLD : BK_DIV;
                end
            end
            BK_DIV:
            begin
                rem_next  = ge ? rem_dbl - scale_ext : rem_dbl;
                frac_next = {frac_reg[FRAC_BITS-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRAC_BITS - 1))
                    state_next = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_error_next = bad;
                    out_value_next = bad ? '0 : (neg_reg ? ('0 - mag) : mag);
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        err_reg       <= err_next;
        whole_reg     <= whole_next;
        frac_reg      <= frac_next;
        rem_reg       <= rem_next;
        scale_reg     <= scale_next;
        step_reg      <= step_next;
        out_value_reg <= out_value_next;
        out_error_reg <= out_error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/dtf_checker.sv -----
// Port-level checker for the decimal text to fixed point unit, bound to the top level.
`timescale 1ns / 1ps

module dtf_checker
    import dtf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [31:0]       m_axis_tdata,
    input  logic              m_axis_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result transaction changed while stalled");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 32'd0))
        else $error("error result carries a nonzero value");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            !m_axis_tdata[31] &&
            ((!m_axis_tdata[30] && (m_axis_tdata[30:0] <= VALUE_POS_MAX)) ||
             (m_axis_tdata[30] && (m_axis_tdata[30:0] >= VALUE_NEG_MIN))))
        else $error("accepted value beyond the largest allowed magnitude");

    a_limit_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && pwrite && penable && pready && (paddr[ADDR_W-1:2] == REG_IDX_LIMIT) |=>
            (prdata[LIMIT_W-1:0] == $past(pwdata[LIMIT_W-1:0])) ||
            (paddr[ADDR_W-1:2] != REG_IDX_LIMIT))
        else $error("limit register does not read back the written value");

endmodule

bind decimal_text_to_fixed_point_unit dtf_checker u_dtf_checker (.*);
